### rtl/nbe_pkg.sv
// Shared types, codes and constants of the NetBIOS name encoder.
package nbe_pkg;

    localparam int NAME_BYTES    = 16;
    localparam int POS_W         = 5;
    localparam int MAX_LABEL_DEF = 63;
    localparam int OUT_TDATA_W   = 24;

    localparam logic [7:0] NAME_LEN_BYTE = 8'd32;
    localparam logic [7:0] LETTER_BASE   = 8'h41;
    localparam logic [3:0] NIBBLE_MASK   = 4'hF;
    localparam logic [7:0] DOT_CHAR      = 8'h2E;

    localparam logic [1:0] CMD_NAME  = 2'd0;
    localparam logic [1:0] CMD_SCOPE = 2'd1;
    localparam logic [1:0] CMD_END   = 2'd2;

    localparam logic [1:0] COUNT_ONE = 2'd1;
    localparam logic [1:0] COUNT_TWO = 2'd2;

    typedef struct packed {
        logic       valid;
        logic [7:0] first;
        logic [7:0] second;
        logic [1:0] count;
        logic       last;
    } result_t;

    typedef struct packed {
        logic start;
        logic closing;
    } flush_cmd_t;

    function automatic logic [7:0] nibble_letter(input logic [3:0] nib);
        return LETTER_BASE + {4'b0000, nib & NIBBLE_MASK};
    endfunction

endpackage

### rtl/netbios_name_encoder_core.sv
// Top level of the NetBIOS first-level name encoder.
// Output: a name byte's result reaches the output register in the cycle after its transfer; the
//   first name byte adds its letter pair as a later second result, input held off meanwhile.
// Throughput: one name byte or scope character per cycle with a free output and no pending pair;
//   a dot or end flush holds input off over ceil((label length + 1 + closing zero) / 2) results.
// Reset: rst_n clears position, label length, sequencer and output valid; label memory unreset.
module netbios_name_encoder_core #(
    parameter int MAX_LABEL = nbe_pkg::MAX_LABEL_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] data_byte
    input  logic [1:0]                      s_tuser,   // [1:0] command
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [nbe_pkg::OUT_TDATA_W-1:0] m_tdata,   // [7:0] first_byte, [15:8] second_byte,
                                                       // [17:16] byte_count, zero above
    output logic                            m_tlast    // last_of_run
);

    import nbe_pkg::*;

    localparam int LW = $clog2(MAX_LABEL + 1);
    localparam int AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;

    // name and label bookkeeping
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [LW-1:0]    len_reg, len_next;

    // second result of the first name byte, waiting for the output slot
    logic             pend_reg, pend_next;
    logic [7:0]       pend_hi_reg, pend_hi_next;
    logic [7:0]       pend_lo_reg, pend_lo_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_first_reg, out_first_next;
    logic [7:0]       out_second_reg, out_second_next;
    logic [1:0]       out_count_reg, out_count_next;
    logic             out_last_reg, out_last_next;

    logic             slot_free, accept;
    logic [1:0]       command;
    logic [7:0]       data_byte;
    logic [7:0]       hi_letter, lo_letter;
    logic             is_name, is_scope, is_dot, is_store, is_end;

    flush_cmd_t       flush_cmd;
    result_t          seq_res;
    logic             seq_busy;
    logic             rd_en;
    logic [AW-1:0]    rd_addr0, rd_addr1;
    logic [7:0]       rd_data0, rd_data1;

    assign command   = s_tuser;
    assign data_byte = s_tdata;
    assign hi_letter = nibble_letter(data_byte[7:4]);
    assign lo_letter = nibble_letter(data_byte[3:0]);

    // Take a new item only with no flush or pending letter pair and a free output slot.
    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = !pend_reg && !seq_busy && slot_free;
    assign accept    = s_tvalid && s_tready;

    assign is_name  = accept && (command == CMD_NAME) && (pos_reg < POS_W'(NAME_BYTES));
    assign is_scope = accept && (command == CMD_SCOPE);
    assign is_dot   = is_scope && (data_byte == DOT_CHAR);
    assign is_store = is_scope && !is_dot && (len_reg < LW'(MAX_LABEL));
    assign is_end   = accept && (command == CMD_END);

    assign flush_cmd.start   = is_dot || is_end;
    assign flush_cmd.closing = is_end;

    nbe_label_ram #(
        .DEPTH (MAX_LABEL),
        .AW    (AW)
    ) u_ram (
        .clk    (clk),
        .we     (is_store),
        .waddr  (len_reg[AW-1:0]),
        .wdata  (data_byte),
        .re     (rd_en),
        .raddr0 (rd_addr0),
        .raddr1 (rd_addr1),
        .rdata0 (rd_data0),
        .rdata1 (rd_data1)
    );

    // Writes only happen while the sequencer is idle, so reads never overlap a write.
    nbe_flush_seq #(
        .MAX_LABEL (MAX_LABEL),
        .LW        (LW),
        .AW        (AW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (flush_cmd),
        .start_len (len_reg),
        .slot_free (slot_free),
        .rd_data0  (rd_data0),
        .rd_data1  (rd_data1),
        .rd_en     (rd_en),
        .rd_addr0  (rd_addr0),
        .rd_addr1  (rd_addr1),
        .res       (seq_res),
        .busy      (seq_busy)
    );

    always_comb
    begin
        pos_next        = pos_reg;
        len_next        = len_reg;
        pend_next       = pend_reg;
        pend_hi_next    = pend_hi_reg;
        pend_lo_next    = pend_lo_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_first_next  = out_first_reg;
        out_second_next = out_second_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;

        // advance name position; end clears it
        if (is_name)
        begin
            pos_next = pos_reg + POS_W'(1);
        end
        else if (is_end)
        begin
            pos_next = '0;
        end

        if (is_store)
        begin
            len_next = len_reg + LW'(1);
        end
        else if (flush_cmd.start)
        begin
            len_next = '0;
        end

        // The three output sources are mutually exclusive by construction.
        if (is_name)
        begin
            out_valid_next = 1'b1;
            if (pos_reg == '0)
            begin
                // length byte travels alone, the letter pair follows
                out_first_next  = NAME_LEN_BYTE;
                out_second_next = 8'h00;
                out_count_next  = COUNT_ONE;
                out_last_next   = 1'b0;
                pend_next       = 1'b1;
                pend_hi_next    = hi_letter;
                pend_lo_next    = lo_letter;
            end
            else
            begin
                out_first_next  = hi_letter;
                out_second_next = lo_letter;
                out_count_next  = COUNT_TWO;
                out_last_next   = 1'b1;
            end
        end
        else if (pend_reg && slot_free)
        begin
            out_valid_next  = 1'b1;
            out_first_next  = pend_hi_reg;
            out_second_next = pend_lo_reg;
            out_count_next  = COUNT_TWO;
            out_last_next   = 1'b1;
            pend_next       = 1'b0;
        end
        else if (seq_res.valid && slot_free)
        begin
            out_valid_next  = 1'b1;
            out_first_next  = seq_res.first;
            out_second_next = seq_res.second;
            out_count_next  = seq_res.count;
            out_last_next   = seq_res.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            len_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers: hold without reset
    always_ff @(posedge clk)
    begin
        pend_hi_reg    <= pend_hi_next;
        pend_lo_reg    <= pend_lo_next;
        out_first_reg  <= out_first_next;
        out_second_reg <= out_second_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {(OUT_TDATA_W - 18)'(0), out_count_reg, out_second_reg, out_first_reg};

    a_pend_no_flush: assert property (@(posedge clk) disable iff (!rst_n)
        !(pend_reg && seq_busy))
        else $error("pending letter pair overlaps a label flush");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(NAME_BYTES))
        else $error("name position ran past the name length");

    a_flush_clears_len: assert property (@(posedge clk) disable iff (!rst_n)
        flush_cmd.start |=> (len_reg == '0) && seq_busy)
        else $error("flush did not clear the label or start the sequencer");

    a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_count_reg == COUNT_ONE) || (out_count_reg == COUNT_TWO))
        else $error("illegal byte count in output");

    a_single_zero_second: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_count_reg == COUNT_ONE)) |-> (out_second_reg == 8'h00))
        else $error("second byte not zero on a single-byte result");

endmodule

### rtl/nbe_label_ram.sv
// Label character store: one write port, two registered read ports.
module nbe_label_ram #(
    parameter int DEPTH = 63,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr0,
    input  logic [AW-1:0] raddr1,
    output logic [7:0]    rdata0,
    output logic [7:0]    rdata1
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata0 <= mem[raddr0];
            rdata1 <= mem[raddr1];
        end
    end

endmodule

### rtl/nbe_flush_seq.sv
// Label flush sequencer: reads the store two characters at a time and forms results.
module nbe_flush_seq #(
    parameter int MAX_LABEL = 63,
    parameter int LW        = 6,
    parameter int AW        = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  nbe_pkg::flush_cmd_t cmd,
    input  logic [LW-1:0]       start_len,
    input  logic                slot_free,
    input  logic [7:0]          rd_data0,
    input  logic [7:0]          rd_data1,
    output logic                rd_en,
    output logic [AW-1:0]       rd_addr0,
    output logic [AW-1:0]       rd_addr1,
    output nbe_pkg::result_t    res,
    output logic                busy
);

    import nbe_pkg::*;

    localparam int BW = $clog2(MAX_LABEL + 3);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_WT   = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [LW-1:0] len_reg, len_next;
    logic          close_reg, close_next;
    logic [BW-1:0] k_reg, k_next;

    logic [BW-1:0] nbytes;
    logic [BW-1:0] len_ext;
    logic [BW-1:0] j0, j1, am0;
    logic          mem0, mem1, has1, last;

    always_comb
    begin
        len_ext = BW'(len_reg);
        nbytes  = len_ext + BW'(1) + BW'(close_reg && (len_reg != '0));
        j0      = {k_reg[BW-2:0], 1'b0};
        j1      = j0 + BW'(1);
        am0     = j0 - BW'(1);
        mem0    = (j0 != '0) && (j0 <= len_ext);
        mem1    = (j1 <= len_ext);
        has1    = (j1 < nbytes);
        last    = ({1'b0, j0} + (BW+1)'(2)) >= {1'b0, nbytes};
        rd_addr0 = mem0 ? am0[AW-1:0] : '0;
        rd_addr1 = mem1 ? j0[AW-1:0] : '0;
    end

    always_comb
    begin
        res.valid  = (state_reg == S_WT);
        res.first  = (j0 == '0) ? 8'(len_reg) : (mem0 ? rd_data0 : 8'h00);
        res.second = (has1 && mem1) ? rd_data1 : 8'h00;
        res.count  = has1 ? COUNT_TWO : COUNT_ONE;
        res.last   = last;
    end

    assign rd_en = (state_reg == S_RD);
    assign busy  = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        close_next = close_reg;
        k_next     = k_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.start)
                begin
                    len_next   = start_len;
                    close_next = cmd.closing;
                    k_next     = '0;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_WT;
            end
            S_WT:
            begin
                if (slot_free)
                begin
                    if (last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + BW'(1);
                        state_next = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
            close_reg <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            close_reg <= close_next;
            k_reg     <= k_next;
        end
    end

endmodule

### verif/netbios_name_encoder_core_checker.sv
`timescale 1ns / 1ps
// Result checker for the name encoder: predicts encoded words and compares each transfer.
module netbios_name_encoder_core_checker #(
    parameter int MAX_LABEL = nbe_pkg::MAX_LABEL_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [7:0]                      s_tdata,
    input  logic [1:0]                      s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [nbe_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                            m_tlast,
    output int                              fail_count,
    output int                              pending
);

    import nbe_pkg::*;

    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
        logic [1:0] count;
        logic       last;
    } enc_word_t;

    enc_word_t  encoded_q[$];
    logic [7:0] byte_run[$];

    logic [4:0] name_pos;
    logic [7:0] label_chars[MAX_LABEL];
    logic [5:0] label_len;

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    // Pack the pending bytes two to a word; only a closing run marks its final word.
    task automatic emit_run(input logic closes_run);
        enc_word_t w;
        int        i;
        for (i = 0; i < byte_run.size(); i += 2)
        begin
            w.first = byte_run[i];
            if (i + 1 < byte_run.size())
            begin
                w.second = byte_run[i + 1];
                w.count  = COUNT_TWO;
            end
            else
            begin
                w.second = 8'h00;
                w.count  = COUNT_ONE;
            end
            w.last = closes_run && (i + 2 >= byte_run.size());
            encoded_q.push_back(w);
        end
        byte_run.delete();
    endtask

    task automatic flush_label(input logic closing);
        int i;
        byte_run.delete();
        byte_run.push_back({2'b00, label_len});
        for (i = 0; i < label_len; i++)
            byte_run.push_back(label_chars[i]);
        if (closing && label_len != 0)
            byte_run.push_back(8'h00);
        emit_run(1'b1);
        label_len = '0;
    endtask

    task automatic encode_item(input logic [1:0] cmd, input logic [7:0] data);
        logic [7:0] hi_letter;
        logic [7:0] lo_letter;
        hi_letter = LETTER_BASE + {4'b0000, data[7:4]};
        lo_letter = LETTER_BASE + {4'b0000, data[3:0]};
        case (cmd)
            CMD_NAME:
            begin
                if (name_pos < NAME_BYTES)
                begin
                    if (name_pos == 0)
                    begin
                        byte_run.push_back(NAME_LEN_BYTE);
                        emit_run(1'b0);
                    end
                    byte_run.push_back(hi_letter);
                    byte_run.push_back(lo_letter);
                    emit_run(1'b1);
                    name_pos++;
                end
            end
            CMD_SCOPE:
            begin
                if (data == DOT_CHAR)
                    flush_label(1'b0);
                else if (label_len < MAX_LABEL)
                begin
                    label_chars[label_len] = data;
                    label_len++;
                end
            end
            CMD_END:
            begin
                flush_label(1'b1);
                name_pos = '0;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_field(input string field, input logic [7:0] expected,
                               input logic [7:0] actual);
        if (expected !== actual)
        begin
            $error("%s mismatch: expected %0h, actual %0h", field, expected, actual);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        enc_word_t w;
        if (!rst_n)
        begin
            name_pos  = '0;
            label_len = '0;
            encoded_q.delete();
            byte_run.delete();
            pending = 0;
        end
        else
        begin
            // Check the outgoing transfer first; an input taken at this edge cannot cause it.
            if (m_tvalid && m_tready)
            begin
                if (encoded_q.size() == 0)
                begin
                    $error("unexpected result: tdata %0h, tlast %0b", m_tdata, m_tlast);
                    fail_count++;
                end
                else
                begin
                    w = encoded_q.pop_front();
                    check_field("first_byte", w.first, m_tdata[7:0]);
                    check_field("second_byte", w.second, m_tdata[15:8]);
                    check_field("byte_count", {6'd0, w.count}, {6'd0, m_tdata[17:16]});
                    check_field("last_of_run", {7'd0, w.last}, {7'd0, m_tlast});
                    check_field("tdata padding", 8'h00, 8'(m_tdata[OUT_TDATA_W-1:18]));
                end
            end
            if (s_tvalid && s_tready)
                encode_item(s_tuser, s_tdata);
            pending = encoded_q.size();
        end
    end

endmodule

### verif/netbios_name_encoder_core_test.sv
`timescale 1ns / 1ps
// Testbench top for the name encoder: drives stimulus, paces both sides, prints the verdict.
module netbios_name_encoder_core_test;

    import nbe_pkg::*;

    // Command code the block ignores.
    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS = 330;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata  = 8'h00;
    logic [1:0]             s_tuser  = CMD_NAME;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    int fail_count;
    int pending;

    // Pacing knobs, in percent: chance per cycle that the sender idles / receiver stalls.
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    // Input transfers sent, the ignored command code excluded.
    int sent = 0;

    netbios_name_encoder_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    netbios_name_encoder_core_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    // Receiver: re-roll the stall decision every cycle at the falling edge.
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= snk_stall_pct);

    // Hard stop in case the block hangs.
    initial
    begin
        #10_000_000;
        $display("netbios_name_encoder_core test failed");
        $finish;
    end

    // Offer one item and hold it until the transfer happens. Called and returns at a
    // falling edge; valid stays high on return so back-to-back items need no gap.
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] data);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tuser  <= cmd;
        s_tdata  <= data;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        if (cmd != CMD_UNUSED)
            sent++;
    endtask

    // Drop valid and hold off until every predicted word has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    // Name bytes lean on the extremes so the letters A and P show up often.
    function automatic logic [7:0] name_char();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 8'h00;
        if (pick == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Any label character except the dot, which would cut the label.
    function automatic logic [7:0] label_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == DOT_CHAR)
            c = c + 8'd1;
        return c;
    endfunction

    // One name: mostly well-formed (name bytes, dotted scope, end), sometimes plain noise.
    // The forced form carries extra name bytes and a label of 60 to 70 characters.
    task automatic random_name(input bit forced);
        int name_len;
        int labels;
        int lab_len;
        int pick;
        int l;
        int i;
        if (!forced && $urandom_range(99) < 15)
        begin
            repeat ($urandom_range(1, 12))
                send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
        else
        begin
            pick = $urandom_range(99);
            if (forced || pick < 10)
                name_len = $urandom_range(17, 19);
            else if (pick < 15)
                name_len = $urandom_range(0, 15);
            else
                name_len = NAME_BYTES;
            if (forced)
                name_len = 18;
            for (i = 0; i < name_len; i++)
                send_item(CMD_NAME, name_char());

            labels = forced ? 1 : $urandom_range(0, 3);
            for (l = 0; l < labels; l++)
            begin
                if (forced || $urandom_range(99) < 8)
                    lab_len = $urandom_range(60, 70);
                else
                    lab_len = $urandom_range(0, 8);
                for (i = 0; i < lab_len; i++)
                begin
                    // Mixed order: a stray name byte or an ignored command inside the scope.
                    pick = $urandom_range(99);
                    if (pick < 2)
                        send_item(CMD_NAME, name_char());
                    else if (pick < 4)
                        send_item(CMD_UNUSED, 8'($urandom_range(0, 255)));
                    send_item(CMD_SCOPE, label_char());
                end
                if (l + 1 < labels)
                    send_item(CMD_SCOPE, DOT_CHAR);
            end
            send_item(CMD_END, 8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        int base;
        int phase;
        bit first;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, no idling on either side.
        send_item(CMD_NAME, 8'h00);          // first name byte: length byte 32 alone
        send_item(CMD_NAME, 8'hFF);
        send_item(CMD_NAME, 8'h5A);
        send_item(CMD_SCOPE, 8'h61);
        send_item(CMD_SCOPE, 8'h00);
        send_item(CMD_SCOPE, 8'hFF);
        send_item(CMD_SCOPE, DOT_CHAR);      // dot flushes the label without a closing zero
        send_item(CMD_SCOPE, 8'h63);
        send_item(CMD_UNUSED, 8'hFF);        // ignored, state untouched
        send_item(CMD_END, 8'h00);           // short name, label closed with zero
        send_item(CMD_END, 8'hFF);           // no name, empty scope: single zero byte
        send_item(CMD_SCOPE, DOT_CHAR);      // empty label flush: length byte 0 alone
        send_item(CMD_NAME, 8'h81);
        send_item(CMD_SCOPE, 8'h78);
        send_item(CMD_NAME, 8'h7E);          // name byte after scope characters
        send_item(CMD_END, 8'h00);

        // Hold the sender until the block has emptied.
        drain();

        // Random part across four pacing phases.
        base  = sent;
        first = 1'b1;
        while (sent - base < RANDOM_ITEMS)
        begin
            phase = (sent - base) * 4 / RANDOM_ITEMS;
            case (phase)
                0:
                begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct  = 71;
                    snk_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 71;
                end
                default:
                begin
                    src_idle_pct  = 16;
                    snk_stall_pct = 16;
                end
            endcase
            random_name(first);
            first = 1'b0;
        end

        drain();
        repeat (20) @(negedge clk);

        if (fail_count == 0)
            $display("netbios_name_encoder_core test passed");
        else
            $display("netbios_name_encoder_core test failed");
        $finish;
    end

endmodule

### sim.f
rtl/nbe_pkg.sv
rtl/nbe_label_ram.sv
rtl/nbe_flush_seq.sv
rtl/netbios_name_encoder_core.sv
verif/netbios_name_encoder_core_checker.sv
verif/netbios_name_encoder_core_test.sv
